>>> rtl/tmdm_pkg.sv
`timescale 1ns / 1ps

package tmdm_pkg;

  // Batch size limit and field layout
  localparam int MAX_READINGS_DEF = 16;
  localparam int NUM_FIELDS       = 5;

  localparam int TEMP_W  = 15;
  localparam int HUM_W   = 14;
  localparam int PRESS_W = 17;
  localparam int HEAT_W  = 16;
  localparam int DEW_W   = 15;
  localparam int USED_W  = 5;

  // Signed width that holds any one field (unsigned pressure needs 18)
  localparam int FIELD_XW = 18;
  // Base of the running-sum width; the count width is added on top
  localparam int SUM_BASE_W = 18;

  // Field slots
  localparam int F_TEMP  = 0;
  localparam int F_HUM   = 1;
  localparam int F_PRESS = 2;
  localparam int F_HEAT  = 3;
  localparam int F_DEW   = 4;

  // Control of one divider lane
  typedef struct packed {
    logic ld;
    logic abs;
    logic step;
  } lane_ctl_t;

endpackage

>>> rtl/tmdm_queue.sv
`timescale 1ns / 1ps

module tmdm_queue #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] pop_data,
  output logic             empty
);

  logic [Width-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold job payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/tmdm_front.sv
`timescale 1ns / 1ps

module tmdm_front #(
  parameter int MaxReadings = tmdm_pkg::MAX_READINGS_DEF,
  parameter int CntW        = 5,
  parameter int SumW        = 23
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_push,
  output logic                                          in_full,
  input  logic signed [tmdm_pkg::TEMP_W-1:0]            in_temperature,
  input  logic        [tmdm_pkg::HUM_W-1:0]             in_humidity,
  input  logic        [tmdm_pkg::PRESS_W-1:0]           in_pressure,
  input  logic signed [tmdm_pkg::HEAT_W-1:0]            in_heat_index,
  input  logic signed [tmdm_pkg::DEW_W-1:0]             in_dew_point,
  input  logic                                          in_last,
  input  logic                                          q_full,
  output logic                                          q_push,
  output logic [tmdm_pkg::NUM_FIELDS-1:0][SumW-1:0]     q_sum,
  output logic [tmdm_pkg::NUM_FIELDS-1:0][SumW-1:0]     q_drop,
  output logic [CntW-1:0]                               q_used,
  output logic                                          q_ovf
);

  localparam int NF = tmdm_pkg::NUM_FIELDS;
  localparam int XW = tmdm_pkg::FIELD_XW;

  logic signed [XW-1:0]   rd [NF];
  logic signed [SumW-1:0] sum_r [NF];
  logic signed [SumW-1:0] sum_upd [NF];
  logic signed [SumW-1:0] sum_nxt [NF];
  logic signed [XW-1:0]   first_r [NF];
  logic signed [XW-1:0]   first_upd [NF];
  logic signed [XW-1:0]   low_r [NF];
  logic signed [XW-1:0]   low_upd [NF];
  logic signed [XW-1:0]   high_r [NF];
  logic signed [XW-1:0]   high_upd [NF];
  logic [CntW-1:0]        cnt_r, cnt_upd, cnt_nxt;
  logic                   extr_r, extr_upd, extr_nxt;
  logic                   ovf_r, ovf_upd, ovf_nxt;
  logic                   accept, take, is_first, go_low, go_high, short_batch;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && in_last;

  // Widen each field to a common signed width
  assign rd[tmdm_pkg::F_TEMP]  = XW'(in_temperature);
  assign rd[tmdm_pkg::F_HUM]   = XW'(in_humidity);
  assign rd[tmdm_pkg::F_PRESS] = XW'(in_pressure);
  assign rd[tmdm_pkg::F_HEAT]  = XW'(in_heat_index);
  assign rd[tmdm_pkg::F_DEW]   = XW'(in_dew_point);

  assign take     = (cnt_r < CntW'(MaxReadings));
  assign is_first = (cnt_r == '0);
  assign go_low   = rd[tmdm_pkg::F_TEMP] < low_r[tmdm_pkg::F_TEMP];
  assign go_high  = rd[tmdm_pkg::F_TEMP] > high_r[tmdm_pkg::F_TEMP];

  // Fold the reading into sums and extreme records; past the limit, flag overflow
  always_comb begin
    sum_upd   = sum_r;
    first_upd = first_r;
    low_upd   = low_r;
    high_upd  = high_r;
    cnt_upd   = cnt_r;
    extr_upd  = extr_r;
    ovf_upd   = ovf_r;
    if (take) begin
      for (int i = 0; i < NF; i++) begin
        sum_upd[i] = sum_r[i] + SumW'(rd[i]);
      end
      cnt_upd = cnt_r + CntW'(1);
      if (is_first) begin
        first_upd = rd;
        low_upd   = rd;
        high_upd  = rd;
        extr_upd  = 1'b1;
      end else begin
        if (go_low) begin
          low_upd  = rd;
          extr_upd = 1'b0;
        end
        if (go_high) begin
          high_upd = rd;
          extr_upd = 1'b0;
        end
      end
    end else begin
      ovf_upd = 1'b1;
    end
  end

  // Build the job for the back part
  assign short_batch = (CntW + 2)'(cnt_upd) <= (CntW + 2)'(2);

  always_comb begin
    for (int i = 0; i < NF; i++) begin
      if (short_batch) begin
        q_sum[i]  = SumW'(first_upd[i]);
        q_drop[i] = '0;
      end else if (extr_upd) begin
        q_sum[i]  = sum_upd[i];
        q_drop[i] = SumW'(first_upd[i]);
      end else begin
        q_sum[i]  = sum_upd[i];
        q_drop[i] = SumW'(low_upd[i]) + SumW'(high_upd[i]);
      end
    end
    if (short_batch) begin
      q_used = CntW'(1);
    end else if (extr_upd) begin
      q_used = cnt_upd - CntW'(1);
    end else begin
      q_used = cnt_upd - CntW'(2);
    end
    q_ovf = ovf_upd;
  end

  // Commit the updated batch, or clear it after its last reading
  always_comb begin
    cnt_nxt  = cnt_r;
    extr_nxt = extr_r;
    ovf_nxt  = ovf_r;
    sum_nxt  = sum_r;
    if (accept) begin
      if (in_last) begin
        cnt_nxt  = '0;
        extr_nxt = 1'b1;
        ovf_nxt  = 1'b0;
        for (int i = 0; i < NF; i++) begin
          sum_nxt[i] = '0;
        end
      end else begin
        cnt_nxt  = cnt_upd;
        extr_nxt = extr_upd;
        ovf_nxt  = ovf_upd;
        sum_nxt  = sum_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      extr_r <= 1'b1;
      ovf_r  <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      cnt_r  <= cnt_nxt;
      extr_r <= extr_nxt;
      ovf_r  <= ovf_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Hold the stored readings
  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= first_upd;
      low_r   <= low_upd;
      high_r  <= high_upd;
    end
  end

endmodule

>>> rtl/tmdm_div_lane.sv
`timescale 1ns / 1ps

module tmdm_div_lane #(
  parameter int CntW = 5,
  parameter int SumW = 23
) (
  input  logic                      clk,
  input  tmdm_pkg::lane_ctl_t       ctl,
  input  logic signed [SumW-1:0]    sum,
  input  logic signed [SumW-1:0]    drop,
  input  logic        [CntW-1:0]    divisor,
  output logic signed [SumW-1:0]    quot
);

  logic signed [SumW-1:0] diff;
  logic [SumW-1:0]        acc_r;
  logic [CntW-1:0]        rem_r;
  logic                   neg_r;
  logic [CntW:0]          trial;
  logic [CntW:0]          trial_sub;
  logic                   fits;

  // One restoring step: shift in a dividend bit, subtract if it fits
  assign diff      = sum - drop;
  assign trial     = {rem_r, acc_r[SumW-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      acc_r <= diff;
      neg_r <= diff[SumW-1];
      rem_r <= '0;
    end else if (ctl.abs) begin
      if (neg_r) begin
        acc_r <= -acc_r;
      end
    end else if (ctl.step) begin
      acc_r <= {acc_r[SumW-2:0], fits};
      rem_r <= fits ? trial_sub[CntW-1:0] : trial[CntW-1:0];
    end
  end

  // Restore the sign: truncation toward zero
  assign quot = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

>>> rtl/tmdm_back.sv
`timescale 1ns / 1ps

module tmdm_back #(
  parameter int CntW = 5,
  parameter int SumW = 23
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_empty,
  output logic                                          q_pop,
  input  logic [tmdm_pkg::NUM_FIELDS-1:0][SumW-1:0]     q_sum,
  input  logic [tmdm_pkg::NUM_FIELDS-1:0][SumW-1:0]     q_drop,
  input  logic [CntW-1:0]                               q_used,
  input  logic                                          q_ovf,
  output logic                                          out_empty,
  input  logic                                          out_pop,
  output logic signed [tmdm_pkg::TEMP_W-1:0]            out_avg_temperature,
  output logic        [tmdm_pkg::HUM_W-1:0]             out_avg_humidity,
  output logic        [tmdm_pkg::PRESS_W-1:0]           out_avg_pressure,
  output logic signed [tmdm_pkg::HEAT_W-1:0]            out_avg_heat_index,
  output logic signed [tmdm_pkg::DEW_W-1:0]             out_avg_dew_point,
  output logic        [tmdm_pkg::USED_W-1:0]            out_used_count,
  output logic                                          out_overflowed
);

  localparam int NF    = tmdm_pkg::NUM_FIELDS;
  localparam int StepW = $clog2(SumW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ABS  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

  back_state_t            state_r, state_nxt;
  logic [StepW-1:0]       step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CntW-1:0]        used_r;
  logic                   ovf_r;
  tmdm_pkg::lane_ctl_t    ctl;
  logic [NF-1:0][SumW-1:0] quot;
  logic                   out_load;

  logic signed [tmdm_pkg::TEMP_W-1:0]  avg_temp_r;
  logic        [tmdm_pkg::HUM_W-1:0]   avg_hum_r;
  logic        [tmdm_pkg::PRESS_W-1:0] avg_press_r;
  logic signed [tmdm_pkg::HEAT_W-1:0]  avg_heat_r;
  logic signed [tmdm_pkg::DEW_W-1:0]   avg_dew_r;
  logic        [tmdm_pkg::USED_W-1:0]  used_cnt_r;
  logic                                ovf_out_r;

  // One divider lane per field, all stepping together
  for (genvar g = 0; g < NF; g++) begin : g_lane
    tmdm_div_lane #(
      .CntW(CntW),
      .SumW(SumW)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .sum    ($signed(q_sum[g])),
      .drop   ($signed(q_drop[g])),
      .divisor(used_r),
      .quot   (quot[g])
    );
  end

  // Sequence load, sign removal, divide steps and result write
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctl       = '0;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          ctl.ld    = 1'b1;
          q_pop     = 1'b1;
          state_nxt = ST_ABS;
        end
      end
      ST_ABS: begin
        ctl.abs   = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        ctl.step = 1'b1;
        step_nxt = step_r + StepW'(1);
        if (step_r == StepW'(SumW - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register: hold until the transfer, reload behind it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      used_r <= q_used;
      ovf_r  <= q_ovf;
    end
    if (out_load) begin
      avg_temp_r  <= quot[tmdm_pkg::F_TEMP][tmdm_pkg::TEMP_W-1:0];
      avg_hum_r   <= quot[tmdm_pkg::F_HUM][tmdm_pkg::HUM_W-1:0];
      avg_press_r <= quot[tmdm_pkg::F_PRESS][tmdm_pkg::PRESS_W-1:0];
      avg_heat_r  <= quot[tmdm_pkg::F_HEAT][tmdm_pkg::HEAT_W-1:0];
      avg_dew_r   <= quot[tmdm_pkg::F_DEW][tmdm_pkg::DEW_W-1:0];
      used_cnt_r  <= tmdm_pkg::USED_W'(used_r);
      ovf_out_r   <= ovf_r;
    end
  end

  assign out_empty           = !out_valid_r;
  assign out_avg_temperature = avg_temp_r;
  assign out_avg_humidity    = avg_hum_r;
  assign out_avg_pressure    = avg_press_r;
  assign out_avg_heat_index  = avg_heat_r;
  assign out_avg_dew_point   = avg_dew_r;
  assign out_used_count      = used_cnt_r;
  assign out_overflowed      = ovf_out_r;

endmodule

>>> rtl/trimmed_mean_drop_min_max.sv
`timescale 1ns / 1ps
// Throughput: one reading per cycle while the job queue has room.
// A batch's job enters the job queue with its last reading; the back part then loads it,
// removes the signs, runs the bit-serial divider lanes and writes the result register once it is free or being read.
// The back part works on one job at a time; a two-entry job queue absorbs bursts.
// Reset (rst_n, synchronous, active low) empties the queue and clears the batch.

module trimmed_mean_drop_min_max #(
  parameter int MAX_READINGS = tmdm_pkg::MAX_READINGS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [tmdm_pkg::TEMP_W-1:0]  in_temperature,
  input  logic        [tmdm_pkg::HUM_W-1:0]   in_humidity,
  input  logic        [tmdm_pkg::PRESS_W-1:0] in_pressure,
  input  logic signed [tmdm_pkg::HEAT_W-1:0]  in_heat_index,
  input  logic signed [tmdm_pkg::DEW_W-1:0]   in_dew_point,
  input  logic                                in_last,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [tmdm_pkg::TEMP_W-1:0]  out_avg_temperature,
  output logic        [tmdm_pkg::HUM_W-1:0]   out_avg_humidity,
  output logic        [tmdm_pkg::PRESS_W-1:0] out_avg_pressure,
  output logic signed [tmdm_pkg::HEAT_W-1:0]  out_avg_heat_index,
  output logic signed [tmdm_pkg::DEW_W-1:0]   out_avg_dew_point,
  output logic        [tmdm_pkg::USED_W-1:0]  out_used_count,
  output logic                                out_overflowed
);

  localparam int NF    = tmdm_pkg::NUM_FIELDS;
  localparam int CNT_W = $clog2(MAX_READINGS + 1);
  localparam int SUM_W = tmdm_pkg::SUM_BASE_W + CNT_W;
  localparam int JOB_W = 2 * NF * SUM_W + CNT_W + 1;

  logic                       f_push, q_full, q_empty, q_pop;
  logic [NF-1:0][SUM_W-1:0]   f_sum, f_drop, b_sum, b_drop;
  logic [CNT_W-1:0]           f_used, b_used;
  logic                       f_ovf, b_ovf;
  logic [JOB_W-1:0]           job_in, job_out;

  tmdm_front #(
    .MaxReadings(MAX_READINGS),
    .CntW       (CNT_W),
    .SumW       (SUM_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_temperature(in_temperature),
    .in_humidity   (in_humidity),
    .in_pressure   (in_pressure),
    .in_heat_index (in_heat_index),
    .in_dew_point  (in_dew_point),
    .in_last       (in_last),
    .q_full        (q_full),
    .q_push        (f_push),
    .q_sum         (f_sum),
    .q_drop        (f_drop),
    .q_used        (f_used),
    .q_ovf         (f_ovf)
  );

  // Pack the job for the queue
  assign job_in = {f_ovf, f_used, f_drop, f_sum};
  assign {b_ovf, b_used, b_drop, b_sum} = job_out;

  tmdm_queue #(
    .Width(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_data(job_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (job_out),
    .empty    (q_empty)
  );

  tmdm_back #(
    .CntW(CNT_W),
    .SumW(SUM_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .q_sum              (b_sum),
    .q_drop             (b_drop),
    .q_used             (b_used),
    .q_ovf              (b_ovf),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_avg_temperature(out_avg_temperature),
    .out_avg_humidity   (out_avg_humidity),
    .out_avg_pressure   (out_avg_pressure),
    .out_avg_heat_index (out_avg_heat_index),
    .out_avg_dew_point  (out_avg_dew_point),
    .out_used_count     (out_used_count),
    .out_overflowed     (out_overflowed)
  );

endmodule

>>> tb/trimmed_mean_drop_min_max_test.sv
`timescale 1ns / 1ps

module trimmed_mean_drop_min_max_test;

  localparam int NF              = tmdm_pkg::NUM_FIELDS;
  localparam int BATCH_CAP       = tmdm_pkg::MAX_READINGS_DEF;
  localparam int RANDOM_READINGS = 1700;
  localparam int SETTLE_CYCLES   = 80;
  localparam int MAX_IDLE        = 16;

  // One reading as offered to the block, plus a flag that holds it back
  // until every pending average has been collected
  typedef struct {
    logic signed [tmdm_pkg::TEMP_W-1:0]  temperature;
    logic        [tmdm_pkg::HUM_W-1:0]   humidity;
    logic        [tmdm_pkg::PRESS_W-1:0] pressure;
    logic signed [tmdm_pkg::HEAT_W-1:0]  heat_index;
    logic signed [tmdm_pkg::DEW_W-1:0]   dew_point;
    logic                                last;
    logic                                wait_idle;
  } reading_t;

  typedef struct {
    logic signed [tmdm_pkg::TEMP_W-1:0]  avg_temperature;
    logic        [tmdm_pkg::HUM_W-1:0]   avg_humidity;
    logic        [tmdm_pkg::PRESS_W-1:0] avg_pressure;
    logic signed [tmdm_pkg::HEAT_W-1:0]  avg_heat_index;
    logic signed [tmdm_pkg::DEW_W-1:0]   avg_dew_point;
    logic        [tmdm_pkg::USED_W-1:0]  used_count;
    logic                                overflowed;
  } average_t;

  // How temperatures spread within a random batch
  typedef enum int {
    TEMP_SPREAD,
    TEMP_EQUAL,
    TEMP_TIED
  } temp_mix_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic signed [tmdm_pkg::TEMP_W-1:0]  in_temperature = '0;
  logic        [tmdm_pkg::HUM_W-1:0]   in_humidity = '0;
  logic        [tmdm_pkg::PRESS_W-1:0] in_pressure = '0;
  logic signed [tmdm_pkg::HEAT_W-1:0]  in_heat_index = '0;
  logic signed [tmdm_pkg::DEW_W-1:0]   in_dew_point = '0;
  logic                 in_last = 1'b0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic signed [tmdm_pkg::TEMP_W-1:0]  out_avg_temperature;
  logic        [tmdm_pkg::HUM_W-1:0]   out_avg_humidity;
  logic        [tmdm_pkg::PRESS_W-1:0] out_avg_pressure;
  logic signed [tmdm_pkg::HEAT_W-1:0]  out_avg_heat_index;
  logic signed [tmdm_pkg::DEW_W-1:0]   out_avg_dew_point;
  logic        [tmdm_pkg::USED_W-1:0]  out_used_count;
  logic                 out_overflowed;

  logic in_took = 1'b0;
  logic out_took = 1'b0;

  reading_t feed_q[$];
  average_t avg_q[$];

  int  feed_gap = 0;
  bit  feed_calm = 1'b0;
  int  pop_hold = 0;
  bit  pop_calm = 1'b0;

  int  readings_taken = 0;
  int  batches_closed = 0;
  int  overflow_batches = 0;
  int  averages_checked = 0;
  int  errors = 0;

  // Running batch state of the trimmed-mean predictor
  longint      acc_sum[NF];
  longint      first_rd[NF];
  longint      low_rd[NF];
  longint      high_rd[NF];
  int unsigned batch_len = 0;
  bit          drop_first_only = 1'b1;
  bit          batch_overflow = 1'b0;

  trimmed_mean_drop_min_max dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_temperature      (in_temperature),
    .in_humidity         (in_humidity),
    .in_pressure         (in_pressure),
    .in_heat_index       (in_heat_index),
    .in_dew_point        (in_dew_point),
    .in_last             (in_last),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_avg_temperature (out_avg_temperature),
    .out_avg_humidity    (out_avg_humidity),
    .out_avg_pressure    (out_avg_pressure),
    .out_avg_heat_index  (out_avg_heat_index),
    .out_avg_dew_point   (out_avg_dew_point),
    .out_used_count      (out_used_count),
    .out_overflowed      (out_overflowed)
  );

  // Toggle the 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fold one taken reading into the batch; on the last one queue the average
  function automatic void absorb_reading(reading_t r);
    longint v[NF];
    longint mean[NF];
    longint used;
    average_t a;
    v[tmdm_pkg::F_TEMP]  = r.temperature;
    v[tmdm_pkg::F_HUM]   = r.humidity;
    v[tmdm_pkg::F_PRESS] = r.pressure;
    v[tmdm_pkg::F_HEAT]  = r.heat_index;
    v[tmdm_pkg::F_DEW]   = r.dew_point;
    if (batch_len < BATCH_CAP) begin
      for (int i = 0; i < NF; i++) acc_sum[i] += v[i];
      if (batch_len == 0) begin
        first_rd = v;
        low_rd = v;
        high_rd = v;
        drop_first_only = 1'b1;
      end else begin
        // strict compares: ties keep the earlier reading
        if (v[tmdm_pkg::F_TEMP] < low_rd[tmdm_pkg::F_TEMP]) begin
          low_rd = v;
          drop_first_only = 1'b0;
        end
        if (v[tmdm_pkg::F_TEMP] > high_rd[tmdm_pkg::F_TEMP]) begin
          high_rd = v;
          drop_first_only = 1'b0;
        end
      end
      batch_len++;
    end else begin
      batch_overflow = 1'b1;
    end
    if (!r.last) return;

    if (batch_len <= 2) begin
      mean = first_rd;
      used = 1;
    end else begin
      used = drop_first_only ? batch_len - 1 : batch_len - 2;
      for (int i = 0; i < NF; i++) begin
        mean[i] = acc_sum[i] - (drop_first_only ? first_rd[i] : low_rd[i] + high_rd[i]);
        mean[i] = mean[i] / used;
      end
    end
    a.avg_temperature = tmdm_pkg::TEMP_W'(mean[tmdm_pkg::F_TEMP]);
    a.avg_humidity    = tmdm_pkg::HUM_W'(mean[tmdm_pkg::F_HUM]);
    a.avg_pressure    = tmdm_pkg::PRESS_W'(mean[tmdm_pkg::F_PRESS]);
    a.avg_heat_index  = tmdm_pkg::HEAT_W'(mean[tmdm_pkg::F_HEAT]);
    a.avg_dew_point   = tmdm_pkg::DEW_W'(mean[tmdm_pkg::F_DEW]);
    a.used_count      = tmdm_pkg::USED_W'(used);
    a.overflowed      = batch_overflow;
    avg_q.push_back(a);
    batches_closed++;
    if (batch_overflow) overflow_batches++;

    // start a fresh batch
    for (int i = 0; i < NF; i++) acc_sum[i] = 0;
    batch_len = 0;
    drop_first_only = 1'b1;
    batch_overflow = 1'b0;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, $signed(want), want, $signed(got), got);
    end
  endtask

  function automatic void add_reading(int t, int h, int p, int hi, int d, bit last);
    reading_t r;
    r.temperature = tmdm_pkg::TEMP_W'(t);
    r.humidity    = tmdm_pkg::HUM_W'(h);
    r.pressure    = tmdm_pkg::PRESS_W'(p);
    r.heat_index  = tmdm_pkg::HEAT_W'(hi);
    r.dew_point   = tmdm_pkg::DEW_W'(d);
    r.last        = last;
    r.wait_idle   = 1'b0;
    feed_q.push_back(r);
  endfunction

  // Draw a reading inside the sensor ranges, or anywhere in the field widths
  function automatic reading_t draw_reading(bit wild);
    reading_t r;
    if (wild) begin
      r.temperature = tmdm_pkg::TEMP_W'($urandom);
      r.humidity    = tmdm_pkg::HUM_W'($urandom);
      r.pressure    = tmdm_pkg::PRESS_W'($urandom);
      r.heat_index  = tmdm_pkg::HEAT_W'($urandom);
      r.dew_point   = tmdm_pkg::DEW_W'($urandom);
    end else begin
      r.temperature = tmdm_pkg::TEMP_W'(int'($urandom_range(0, 12500)) - 4000);
      r.humidity    = tmdm_pkg::HUM_W'($urandom_range(0, 10000));
      r.pressure    = tmdm_pkg::PRESS_W'($urandom_range(30000, 110000));
      r.heat_index  = tmdm_pkg::HEAT_W'(int'($urandom_range(0, 24000)) - 4000);
      r.dew_point   = tmdm_pkg::DEW_W'(int'($urandom_range(0, 18500)) - 10000);
    end
    r.last = 1'b0;
    r.wait_idle = 1'b0;
    return r;
  endfunction

  function automatic void queue_batch(int len, temp_mix_t mix, bit idle_first);
    reading_t r;
    int shared_t;
    shared_t = int'($urandom_range(0, 12500)) - 4000;
    for (int i = 0; i < len; i++) begin
      r = draw_reading($urandom_range(0, 99) < 15);
      case (mix)
        TEMP_EQUAL: r.temperature = tmdm_pkg::TEMP_W'(shared_t);
        TEMP_TIED:  r.temperature = tmdm_pkg::TEMP_W'(shared_t + 250 * int'($urandom_range(0, 3)));
        default: ;
      endcase
      r.last = (i == len - 1);
      r.wait_idle = idle_first && (i == 0);
      feed_q.push_back(r);
    end
  endfunction

  // Offer readings: hold each until transferred, then idle for a drawn gap
  always @(negedge clk) begin : feed
    reading_t nxt;
    logic push_nxt;
    push_nxt = in_push;
    if (rst_n) begin
      if (in_push && in_took) begin
        push_nxt = 1'b0;
        feed_gap = feed_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
      end
      if (!push_nxt && feed_q.size() != 0) begin
        if (feed_gap != 0) begin
          feed_gap--;
        end else if (!(feed_q[0].wait_idle && avg_q.size() != 0)) begin
          nxt = feed_q.pop_front();
          in_temperature <= nxt.temperature;
          in_humidity    <= nxt.humidity;
          in_pressure    <= nxt.pressure;
          in_heat_index  <= nxt.heat_index;
          in_dew_point   <= nxt.dew_point;
          in_last        <= nxt.last;
          push_nxt = 1'b1;
        end
      end
    end
    in_push <= push_nxt;
  end

  // Collect averages: after each transfer stall a drawn number of cycles
  always @(negedge clk) begin : drain
    logic pop_nxt;
    pop_nxt = out_pop;
    if (rst_n) begin
      if (out_pop && out_took) begin
        pop_nxt = 1'b0;
        pop_hold = pop_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 39) == 0) pop_calm = !pop_calm;
      end
      if (!pop_nxt) begin
        if (pop_hold == 0) pop_nxt = 1'b1;
        else if (!out_empty) pop_hold--;
      end
    end
    out_pop <= pop_nxt;
  end

  // Watch both channels: predict on input transfers, compare on output ones
  always @(posedge clk) begin : watch
    reading_t seen;
    average_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_push && !in_full;
      out_took <= out_pop && !out_empty;
      if (in_push && !in_full) begin
        seen.temperature = in_temperature;
        seen.humidity    = in_humidity;
        seen.pressure    = in_pressure;
        seen.heat_index  = in_heat_index;
        seen.dew_point   = in_dew_point;
        seen.last        = in_last;
        seen.wait_idle   = 1'b0;
        absorb_reading(seen);
        readings_taken++;
      end
      if (out_pop && !out_empty) begin
        if (avg_q.size() == 0) begin
          errors++;
          $display("%0t: average with none expected, expected nothing, got t=%0d used=%0d",
                   $time, out_avg_temperature, out_used_count);
        end else begin
          want = avg_q.pop_front();
          check_field("avg_temperature", want.avg_temperature, out_avg_temperature);
          check_field("avg_humidity", want.avg_humidity, out_avg_humidity);
          check_field("avg_pressure", want.avg_pressure, out_avg_pressure);
          check_field("avg_heat_index", want.avg_heat_index, out_avg_heat_index);
          check_field("avg_dew_point", want.avg_dew_point, out_avg_dew_point);
          check_field("used_count", want.used_count, out_used_count);
          check_field("overflowed", want.overflowed, out_overflowed);
          averages_checked++;
        end
      end
    end
  end

  initial begin
    int pick;
    int len;
    int queued;
    int total_readings;
    temp_mix_t mix;

    for (int i = 0; i < NF; i++) acc_sum[i] = 0;

    // lone readings at the top and the bottom of every field
    add_reading(16383, 16383, 131071, 32767, 16383, 1);
    add_reading(-16384, 0, 0, -32768, -16384, 1);
    // two readings: the first comes back as it is
    add_reading(8500, 10000, 110000, 20000, 8500, 0);
    add_reading(-4000, 0, 30000, -4000, -10000, 1);
    // equal temperatures at full scale: only the first drops out
    add_reading(16383, 16383, 131071, 32767, 16383, 0);
    add_reading(16383, 16383, 131071, 32767, 16383, 0);
    add_reading(16383, 16383, 131071, 32767, 16383, 1);
    // equal temperatures at the bottom of every field
    add_reading(-16384, 0, 0, -32768, -16384, 0);
    add_reading(-16384, 0, 0, -32768, -16384, 0);
    add_reading(-16384, 0, 0, -32768, -16384, 1);
    // ties at both ends keep the earliest low and high
    add_reading(100, 1, 1000, 10, 1, 0);
    add_reading(50, 2, 2000, 20, 2, 0);
    add_reading(50, 3, 3000, 30, 3, 0);
    add_reading(300, 4, 4000, 40, 4, 0);
    add_reading(300, 5, 5000, 50, 5, 1);
    // odd negative sums truncate toward zero
    add_reading(0, 7, 31001, -3, -5, 0);
    add_reading(-7, 0, 30000, -4, -6, 0);
    add_reading(-8, 3, 30000, -9, -9, 0);
    add_reading(10, 0, 30000, -1, -2, 1);
    // first reading is the highest, a later one takes the low
    add_reading(500, 9000, 90000, 600, 400, 0);
    add_reading(10, 100, 40000, 20, -300, 0);
    add_reading(20, 200, 50000, 30, -200, 1);

    // random batches, some past the size limit; a few wait for an idle block
    queued = 0;
    while (queued < RANDOM_READINGS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) len = 1;
      else if (pick < 12) len = 2;
      else if (pick < 22) len = $urandom_range(BATCH_CAP + 1, BATCH_CAP + 6);
      else len = $urandom_range(3, BATCH_CAP);
      pick = $urandom_range(0, 99);
      if (pick < 10) mix = TEMP_EQUAL;
      else if (pick < 35) mix = TEMP_TIED;
      else mix = TEMP_SPREAD;
      queue_batch(len, mix, queued == 0 || $urandom_range(0, 99) < 3);
      queued += len;
    end
    total_readings = feed_q.size();

    // hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait until every reading is transferred and every average collected
    while (readings_taken < total_readings) @(negedge clk);
    while (avg_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d readings in %0d batches, %0d of them past the %0d-reading limit.",
             readings_taken, batches_closed, overflow_batches, BATCH_CAP);
    $display("Checked %0d averages, %0d mismatches.", averages_checked, errors);
    if (errors == 0 && avg_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
